[design/byte_stuffing_frame_encoder_unit_defines.svh]
// assertion macros for the byte stuffing frame encoder checker
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef BYTE_STUFFING_FRAME_ENCODER_UNIT_DEFINES_SVH
`define BYTE_STUFFING_FRAME_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is low
`define BSFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define BSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsfe_pkg.sv]
// shared types and constants of the byte stuffing frame encoder
// no dependencies
package bsfe_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'd1;

    // register reset values
    localparam logic [7:0] SEPARATOR_RESET = 8'h1C;
    localparam logic [7:0] MAX_BYTES_RESET = 8'd64;

    // leading bytes of a command that pass unescaped
    localparam logic [7:0] HEADER_BYTES = 8'd3;

    // escape codes
    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] ESC_OF_ESC  = 8'h1D;
    localparam logic [7:0] SEP_DEFAULT = 8'h1C;
    localparam logic [7:0] ESC_OF_SEP  = 8'h1E;
    localparam logic [7:0] EXT_LEN     = 8'h00;

    // most output words one input word can cause
    localparam int LIST_LEN = 5;
    localparam int CNT_W    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overlength;
    } t_entry;

    // encoded words of one input word, oldest in entry 0
    typedef struct packed {
        t_entry [LIST_LEN-1:0] ent;
        logic [CNT_W-1:0]      cnt;
    } t_list;

endpackage

[design/bsfe_in_if.sv]
// input channel of the frame encoder: one command byte per word
// no dependencies
interface bsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

[design/bsfe_out_if.sv]
// output channel of the frame encoder: one framed byte per word
// no dependencies
interface bsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       overlength;

    modport source (output valid, output out_byte, output out_last, output overlength,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input overlength,
                  output ready);
endinterface

[design/bsfe_encode.sv]
// escape, limit check, trailer build: one input word per ready cycle
// depends on bsfe_pkg and bsfe_in_if
module bsfe_encode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    bsfe_in_if.sink                        i_in,
    input  logic                           i_take,
    output logic                           o_slot_vld,
    output bsfe_pkg::t_list                o_slot
);
    import bsfe_pkg::*;

    logic [7:0]  r_sep, r_max, r_idx, r_sum;
    logic        r_tl, r_slot_vld;
    t_list       r_slot;

    logic [7:0]  n_idx, n_sum;
    logic        n_tl, n_slot_vld;
    t_list       n_list;

    logic        in_fire, in_lim, hdr, esc;
    logic [1:0]  pn;
    logic [7:0]  b, p0, p1, sum_p, chk;
    logic        ovl;
    t_entry      pay0, pay1, tr0, tr1, tr2;

    assign i_in.ready = !r_slot_vld || i_take;
    assign in_fire    = i_in.valid && i_in.ready;
    assign o_slot_vld = r_slot_vld;
    assign o_slot     = r_slot;

    // encode the word against the frame state
    always_comb begin
        b      = i_in.data_byte;
        in_lim = r_idx < r_max;
        hdr    = r_idx < HEADER_BYTES;
        esc    = in_lim && !hdr && (b == ESC_BYTE || b == SEP_DEFAULT);
        pn     = 2'(in_lim) + 2'(esc);
        p0     = esc ? ESC_BYTE : b;
        p1     = (b == ESC_BYTE) ? ESC_OF_ESC : ESC_OF_SEP;
        sum_p  = r_sum + (in_lim ? p0 : 8'd0) + (esc ? p1 : 8'd0);
        ovl    = r_tl || !in_lim;
        chk    = sum_p + r_sep + EXT_LEN + 8'd1;

        pay0 = '{out_byte: p0, out_last: 1'b0, overlength: 1'b0};
        pay1 = '{out_byte: p1, out_last: 1'b0, overlength: 1'b0};
        tr0  = '{out_byte: r_sep, out_last: 1'b0, overlength: ovl};
        tr1  = '{out_byte: EXT_LEN, out_last: 1'b0, overlength: ovl};
        tr2  = '{out_byte: chk, out_last: 1'b1, overlength: ovl};

        // payload words first, trailer right behind them
        n_list.ent = '0;
        case (pn)
            2'd1: begin
                n_list.ent[0] = pay0;
                n_list.ent[1] = tr0;
                n_list.ent[2] = tr1;
                n_list.ent[3] = tr2;
            end
            2'd2: begin
                n_list.ent[0] = pay0;
                n_list.ent[1] = pay1;
                n_list.ent[2] = tr0;
                n_list.ent[3] = tr1;
                n_list.ent[4] = tr2;
            end
            default: begin
                n_list.ent[0] = tr0;
                n_list.ent[1] = tr1;
                n_list.ent[2] = tr2;
            end
        endcase
        n_list.cnt = {1'b0, pn} + (i_in.frame_end ? CNT_W'(3) : CNT_W'(0));

        // frame state advance
        n_idx = r_idx;
        n_sum = r_sum;
        n_tl  = r_tl;
        if (in_fire) begin
            if (i_in.frame_end) begin
                n_idx = '0;
                n_sum = '0;
                n_tl  = 1'b0;
            end else begin
                n_idx = r_idx + 8'(in_lim);
                n_sum = sum_p;
                n_tl  = ovl;
            end
        end

        // hand-off slot toward the serializer
        n_slot_vld = r_slot_vld && !i_take;
        if (in_fire && n_list.cnt != '0) begin
            n_slot_vld = 1'b1;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep      <= SEPARATOR_RESET;
            r_max      <= MAX_BYTES_RESET;
            r_idx      <= '0;
            r_sum      <= '0;
            r_tl       <= 1'b0;
            r_slot_vld <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_sum      <= n_sum;
            r_tl       <= n_tl;
            r_slot_vld <= n_slot_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEPARATOR: r_sep <= i_cfg_data;
                    CFG_MAX_BYTES: r_max <= i_cfg_data;
                endcase
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (in_fire && n_list.cnt != '0) begin
            r_slot <= n_list;
        end
    end
endmodule

[design/bsfe_serial.sv]
// output buffer: an encoded list goes one word per ready cycle
// depends on bsfe_pkg and bsfe_out_if
module bsfe_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_slot_vld,
    input  bsfe_pkg::t_list i_slot,
    output logic            o_take,
    bsfe_out_if.source      o_out
);
    import bsfe_pkg::*;

    t_entry [LIST_LEN-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  out_fire;

    assign o_out.valid      = r_cnt != '0;
    assign o_out.out_byte   = r_buf[0].out_byte;
    assign o_out.out_last   = r_buf[0].out_last;
    assign o_out.overlength = r_buf[0].overlength;
    assign out_fire         = o_out.valid && o_out.ready;
    assign o_take = i_slot_vld && (r_cnt == '0 || (r_cnt == CNT_W'(1) && out_fire));

    // load a new list or shift out the word just sent
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (o_take) begin
            n_buf = i_slot.ent;
            n_cnt = i_slot.cnt;
        end else if (out_fire) begin
            for (int k = 0; k < LIST_LEN - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    // word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // buffered words
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end
endmodule

[design/byte_stuffing_frame_encoder_unit.sv]
// channel | dir | words
// i_in    | in  | data_byte[7:0], frame_end
// o_out   | out | out_byte[7:0], out_last, overlength
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data[7:0]
//
// one input word is accepted per cycle while the slot is free or taken;
// it leaves 0 to 5 output words, two payload words for an escaped byte,
// and the output side sends one word per cycle while o_out.ready is high
// first output word of an input word is registered in the hand-off slot and
// then in the output buffer before it is valid
// a one-list slot sits between encoder and output buffer, so while the output
// stalls input is taken until a list fills it, then waits until a list moves on
// i_rst_n is synchronous, active low; it clears frame state and restores registers
//
// top level: encoder plus output serializer
// depends on bsfe_pkg, bsfe_in_if, bsfe_out_if, bsfe_encode, bsfe_serial
module byte_stuffing_frame_encoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    bsfe_in_if.sink                        i_in,
    bsfe_out_if.source                     o_out
);
    import bsfe_pkg::*;

    logic  slot_vld;
    logic  take;
    t_list slot;

    // escape and trailer build
    bsfe_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_take     (take),
        .o_slot_vld (slot_vld),
        .o_slot     (slot)
    );

    // one word per cycle out while o_out.ready is high
    bsfe_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot_vld (slot_vld),
        .i_slot     (slot),
        .o_take     (take),
        .o_out      (o_out)
    );
endmodule

[design/bsfe_chk.sv]
// port-level checks on the frame encoder, bound to the top level
// depends on byte_stuffing_frame_encoder_unit_defines.svh
`include "byte_stuffing_frame_encoder_unit_defines.svh"

module bsfe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_ovl
);
    // a stalled output word holds
    `BSFE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output word dropped while stalled")
    `BSFE_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_byte) && $stable(i_out_last) && $stable(i_out_ovl), "output word changed while stalled")

    // checksum is never alone: the trailer word before it was pending with the same flag
    `BSFE_ASSERT_NOW(a_last_trailer, i_out_valid && i_out_ready && i_out_last, $past(i_out_valid) && ($past(i_out_ovl) == i_out_ovl), "checksum word without its trailer")

    // an empty output side never holds off input
    `BSFE_ASSERT_NOW(a_in_open, !i_out_valid, i_in_ready, "input stalled while output empty")
endmodule

bind byte_stuffing_frame_encoder_unit bsfe_chk u_bsfe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_out_ovl   (o_out.overlength)
);
